@@ src/bpt_pkg.sv @@
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types and constants of the bilinear patch tessellator.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int MaxResolution = 64;
  localparam int CoordBits     = 16;
  localparam int IndexBits     = 20;

  localparam int ResW         = 7;
  localparam int StepW        = 17;
  localparam int WeightW      = 17;
  localparam int SubW         = 6;
  localparam int CornerW      = 2;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 17;
  localparam int QDepth       = 2;
  localparam int VertsPerQuad = 4;
  localparam int NumCorners   = 4;
  localparam int NumFields    = 4;

  localparam logic [WeightW-1:0] WeightOne     = 17'h10000;
  localparam logic [ResW-1:0]    ResolutionRst = 7'd10;
  localparam logic [StepW-1:0]   StepRst       = 17'd6554;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_EMIT    = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESOLUTION  = 2'd0,
    CFG_WEIGHT_STEP = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  // command word handed from the front to the back through the queue
  typedef struct packed {
    opcode_e              op;
    logic [CornerW-1:0]   corner;
    logic [WeightW-1:0]   wu0;
    logic [WeightW-1:0]   wu1;
    logic [WeightW-1:0]   wv0;
    logic [WeightW-1:0]   wv1;
  } cmd_ctl_t;

  // tag of one vertex entering the blend pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

endpackage

@@ src/bpt_front.sv @@
// ----------------------------------------------------------------------------
// bpt_front
// Takes commands, holds the configuration, works out the grid weights of a
// sub-quad and queues the command for the back end.
// ----------------------------------------------------------------------------
module bpt_front import bpt_pkg::*; #(
  parameter int MAX_RESOLUTION = MaxResolution,
  parameter int COORD_BITS     = CoordBits
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      cfg_we_i,
  input  logic [CfgIdxW-1:0]                        cfg_idx_i,
  input  logic [CfgDataW-1:0]                       cfg_data_i,
  input  logic [1:0]                                opcode_i,
  input  logic [CornerW-1:0]                        corner_i,
  input  logic signed [COORD_BITS-1:0]              pos_x_i,
  input  logic signed [COORD_BITS-1:0]              pos_y_i,
  input  logic signed [COORD_BITS-1:0]              tex_u_i,
  input  logic signed [COORD_BITS-1:0]              tex_v_i,
  input  logic [SubW-1:0]                           sub_col_i,
  input  logic [SubW-1:0]                           sub_row_i,
  input  logic                                      full_i,
  output logic                                      push_o,
  output cmd_ctl_t                                  ctl_o,
  output logic [NumFields*COORD_BITS-1:0]           data_o
);

  localparam int RW = ($clog2(MAX_RESOLUTION + 1) > ResW) ? $clog2(MAX_RESOLUTION + 1) : ResW;
  localparam int MW = ResW + StepW;
  localparam int PW = MW + 1;

  logic [ResW-1:0]  res_q, res_d;
  logic [StepW-1:0] step_q, step_d;

  logic [RW-1:0]    res_eff;
  logic [ResW-1:0]  col0, col1, row0, row1;
  logic [MW-1:0]    mcol, mrow;
  logic [PW-1:0]    pc0, pc1, pr0, pr1;
  opcode_e          op;

  function automatic logic [WeightW-1:0] sat_weight(input logic far, input logic [PW-1:0] prod);
    if (far || (prod > PW'(WeightOne))) begin
      return WeightOne;
    end
    return prod[WeightW-1:0];
  endfunction

  function automatic logic at_far(input logic [ResW-1:0] k, input logic [RW-1:0] r);
    return (RW'(k) >= r);
  endfunction

  always_comb begin
    res_d  = res_q;
    step_d = step_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESOLUTION:  res_d  = cfg_data_i[ResW-1:0];
        CFG_WEIGHT_STEP: step_d = cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= ResolutionRst;
      step_q <= StepRst;
    end else begin
      res_q  <= res_d;
      step_q <= step_d;
    end
  end

  // clamp resolution to what the block supports
  assign res_eff = (RW'(res_q) > RW'(MAX_RESOLUTION)) ? RW'(MAX_RESOLUTION) : RW'(res_q);

  assign col0 = ResW'(sub_col_i);
  assign col1 = col0 + ResW'(1);
  assign row0 = ResW'(sub_row_i);
  assign row1 = row0 + ResW'(1);

  assign mcol = col0 * step_q;
  assign mrow = row0 * step_q;
  assign pc0  = PW'(mcol);
  assign pr0  = PW'(mrow);
  assign pc1  = pc0 + PW'(step_q);
  assign pr1  = pr0 + PW'(step_q);

  assign op   = opcode_e'(opcode_i);
  assign busy = full_i;

  always_comb begin
    push_o = 1'b0;
    case (op)
      OP_LOAD, OP_EMIT, OP_RESTART: push_o = start && !full_i;
      default: push_o = 1'b0;
    endcase
  end

  always_comb begin
    ctl_o.op     = op;
    ctl_o.corner = corner_i;
    ctl_o.wu0    = sat_weight(at_far(col0, res_eff), pc0);
    ctl_o.wu1    = sat_weight(at_far(col1, res_eff), pc1);
    ctl_o.wv0    = sat_weight(at_far(row0, res_eff), pr0);
    ctl_o.wv1    = sat_weight(at_far(row1, res_eff), pr1);
  end

  assign data_o = {tex_v_i, tex_u_i, pos_y_i, pos_x_i};

endmodule

@@ src/bpt_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// bpt_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module bpt_cmd_fifo import bpt_pkg::*; #(
  parameter int DATA_W = NumFields * CoordBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmd_ctl_t          ctl_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output cmd_ctl_t          ctl_o,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  cmd_ctl_t          ctl_mem_q  [QDepth];
  logic [DATA_W-1:0] data_mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_mem_q[wr_ptr_q]  <= ctl_i;
      data_mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign ctl_o   = ctl_mem_q[rd_ptr_q];
  assign data_o  = data_mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(QDepth));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CntW'(QDepth)))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("command queue read while empty");

endmodule

@@ src/bpt_back.sv @@
// ----------------------------------------------------------------------------
// bpt_back
// Carries out queued commands: corner loads, numbering restarts and the
// issue of the four vertices of a sub-quad, one a cycle.
// ----------------------------------------------------------------------------
module bpt_back import bpt_pkg::*; #(
  parameter int COORD_BITS = CoordBits,
  parameter int INDEX_BITS = IndexBits
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  empty_i,
  input  cmd_ctl_t                                              ctl_i,
  input  logic [NumFields*COORD_BITS-1:0]                       data_i,
  output logic                                                  pop_o,
  output issue_t                                                issue_o,
  output logic [INDEX_BITS-1:0]                                 number_o,
  output logic [WeightW-1:0]                                    wu_o,
  output logic [WeightW-1:0]                                    wv_o,
  output logic [NumCorners-1:0][NumFields-1:0][COORD_BITS-1:0]  corners_o
);

  localparam int KW = $clog2(VertsPerQuad);
  localparam logic [KW-1:0] KLast = KW'(VertsPerQuad - 1);

  back_state_e              state_q, state_d;
  logic [KW-1:0]            k_q, k_d;
  logic [INDEX_BITS-1:0]    cnt_q, cnt_d;
  logic [WeightW-1:0]       wu0_q, wu1_q, wv0_q, wv1_q;
  logic                     wt_load;
  logic [NumCorners-1:0][NumFields*COORD_BITS-1:0] corner_q, corner_d;
  logic                     can_pop;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    corner_d     = corner_q;
    wt_load      = 1'b0;
    issue_o      = '0;

    case (state_q)
      BK_EMIT: begin
        issue_o.valid = 1'b1;
        issue_o.last  = (k_q == KLast);
        k_d           = k_q + KW'(1);
        cnt_d         = cnt_q + INDEX_BITS'(1);
        if (k_q == KLast) begin
          state_d = BK_IDLE;
        end
      end
      default: ;
    endcase

    // next command is taken while the last vertex of a sub-quad goes out
    can_pop = (state_q == BK_IDLE) || (k_q == KLast);
    pop_o   = can_pop && !empty_i;

    if (pop_o) begin
      case (ctl_i.op)
        OP_LOAD: corner_d[ctl_i.corner] = data_i;
        OP_EMIT: begin
          state_d = BK_EMIT;
          k_d     = '0;
          wt_load = 1'b1;
        end
        OP_RESTART: cnt_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      k_q      <= '0;
      cnt_q    <= '0;
      corner_q <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
      corner_q <= corner_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wt_load) begin
      wu0_q <= ctl_i.wu0;
      wu1_q <= ctl_i.wu1;
      wv0_q <= ctl_i.wv0;
      wv1_q <= ctl_i.wv1;
    end
  end

  // vertex order: u steps fastest, then v
  assign wu_o      = k_q[0] ? wu1_q : wu0_q;
  assign wv_o      = k_q[1] ? wv1_q : wv0_q;
  assign number_o  = cnt_q;
  assign corners_o = corner_q;

  a_quad_four_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT && k_q != KLast) |=> (state_q == BK_EMIT))
    else $error("sub-quad issue ended before its fourth vertex");

endmodule

@@ src/bpt_blend.sv @@
// ----------------------------------------------------------------------------
// bpt_blend
// Three-stage bilinear blend of the corner data for one vertex a cycle:
// edge products, edge rounding with the cross product, final rounding.
// ----------------------------------------------------------------------------
module bpt_blend import bpt_pkg::*; #(
  parameter int COORD_BITS = CoordBits,
  parameter int INDEX_BITS = IndexBits
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  issue_t                                                issue_i,
  input  logic [INDEX_BITS-1:0]                                 number_i,
  input  logic [WeightW-1:0]                                    wu_i,
  input  logic [WeightW-1:0]                                    wv_i,
  input  logic [NumCorners-1:0][NumFields-1:0][COORD_BITS-1:0]  corners_i,
  output logic                                                  vertex_valid_o,
  output logic signed [COORD_BITS-1:0]                          vertex_x_o,
  output logic signed [COORD_BITS-1:0]                          vertex_y_o,
  output logic signed [COORD_BITS-1:0]                          vertex_u_o,
  output logic signed [COORD_BITS-1:0]                          vertex_v_o,
  output logic [INDEX_BITS-1:0]                                 vertex_number_o,
  output logic                                                  last_o
);

  localparam int CW = COORD_BITS;
  localparam int PW = CW + WeightW + 2;
  localparam logic signed [PW-1:0] Half  = PW'(32768);
  localparam logic signed [PW-1:0] SatHi = (PW'(1) <<< (CW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);

  localparam int CTl = 0;
  localparam int CTr = 1;
  localparam int CBl = 2;
  localparam int CBr = 3;

  // (b - a) * t with t in Q1.16
  function automatic logic signed [PW-1:0] mul_diff(input logic [CW-1:0] a,
                                                    input logic [CW-1:0] b,
                                                    input logic [WeightW-1:0] t);
    logic signed [CW:0]   d;
    logic signed [PW-1:0] de;
    logic signed [PW-1:0] te;
    d  = {b[CW-1], b} - {a[CW-1], a};
    de = {{(PW-CW-1){d[CW]}}, d};
    te = PW'(t);
    return de * te;
  endfunction

  // a + round(p / 2^16), ties up, saturated
  function automatic logic [CW-1:0] add_round(input logic [CW-1:0] a,
                                              input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] s;
    r = (p + Half) >>> 16;
    s = r + {{(PW-CW){a[CW-1]}}, a};
    if (s > SatHi) begin
      return SatHi[CW-1:0];
    end
    if (s < SatLo) begin
      return SatLo[CW-1:0];
    end
    return s[CW-1:0];
  endfunction

  issue_t                 s1_tag_q, s2_tag_q;
  logic [INDEX_BITS-1:0]  s1_num_q, s2_num_q;
  logic [WeightW-1:0]     s1_wv_q;
  logic signed [PW-1:0]   s1_ptop_q [NumFields];
  logic signed [PW-1:0]   s1_pbot_q [NumFields];
  logic [CW-1:0]          s1_tl_q   [NumFields];
  logic [CW-1:0]          s1_bl_q   [NumFields];
  logic signed [PW-1:0]   s2_p_q    [NumFields];
  logic [CW-1:0]          s2_top_q  [NumFields];
  logic [CW-1:0]          top_c     [NumFields];
  logic [CW-1:0]          bot_c     [NumFields];
  logic [CW-1:0]          res_c     [NumFields];
  logic                   out_valid_q;
  logic                   out_last_q;

  always_comb begin
    for (int j = 0; j < NumFields; j++) begin
      top_c[j] = add_round(s1_tl_q[j], s1_ptop_q[j]);
      bot_c[j] = add_round(s1_bl_q[j], s1_pbot_q[j]);
      res_c[j] = add_round(s2_top_q[j], s2_p_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q    <= '0;
      s2_tag_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_tag_q    <= issue_i;
      s2_tag_q    <= s1_tag_q;
      out_valid_q <= s2_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_num_q <= number_i;
    s1_wv_q  <= wv_i;
    s2_num_q <= s1_num_q;
    for (int j = 0; j < NumFields; j++) begin
      s1_ptop_q[j] <= mul_diff(corners_i[CTl][j], corners_i[CTr][j], wu_i);
      s1_pbot_q[j] <= mul_diff(corners_i[CBl][j], corners_i[CBr][j], wu_i);
      s1_tl_q[j]   <= corners_i[CTl][j];
      s1_bl_q[j]   <= corners_i[CBl][j];
      s2_p_q[j]    <= mul_diff(top_c[j], bot_c[j], s1_wv_q);
      s2_top_q[j]  <= top_c[j];
    end
    vertex_x_o      <= res_c[0];
    vertex_y_o      <= res_c[1];
    vertex_u_o      <= res_c[2];
    vertex_v_o      <= res_c[3];
    vertex_number_o <= s2_num_q;
    out_last_q      <= s2_tag_q.last;
  end

  assign vertex_valid_o = out_valid_q;
  assign last_o         = out_valid_q && out_last_q;

  a_result_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vertex_valid_o |-> $past(issue_i.valid, 3))
    else $error("vertex beat without a matching issue three cycles before");

endmodule

@@ src/bilinear_patch_tessellator_unit.sv @@
// ----------------------------------------------------------------------------
// bilinear_patch_tessellator_unit
// Bilinear tessellation of one warp cell into sub-quad vertices.
//
//  channel   direction  handshake                 payload
//  command   in         start, busy               opcode_i corner_i pos_*_i tex_*_i sub_*_i
//  config    in         cfg_we_i                  cfg_idx_i cfg_data_i
//  vertex    out        vertex_valid_o (strobe)   vertex_*_o vertex_number_o last_o
//
// A load, emit or restart command is taken when start is high and busy low;
// it goes into a two-entry queue, busy is high while that queue is full.
// An emit command gives four vertex beats on consecutive cycles; the back end
// issues one vertex a cycle and takes the next command with the last vertex,
// so queued sub-quads stream back to back. Load and restart commands give no beat.
// A first vertex passes the queue, back end state and blend stage registers.
// Reset clears the corners, the vertex count and the queue; resolution
// resets to 10 and the weight step to 6554. The vertex channel never stalls.
// ----------------------------------------------------------------------------
module bilinear_patch_tessellator_unit import bpt_pkg::*; #(
  parameter int MAX_RESOLUTION = MaxResolution,
  parameter int COORD_BITS     = CoordBits,
  parameter int INDEX_BITS     = IndexBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_idx_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  input  logic [1:0]                    opcode_i,
  input  logic [CornerW-1:0]            corner_i,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic signed [COORD_BITS-1:0]  tex_u_i,
  input  logic signed [COORD_BITS-1:0]  tex_v_i,
  input  logic [SubW-1:0]               sub_col_i,
  input  logic [SubW-1:0]               sub_row_i,
  output logic                          vertex_valid_o,
  output logic signed [COORD_BITS-1:0]  vertex_x_o,
  output logic signed [COORD_BITS-1:0]  vertex_y_o,
  output logic signed [COORD_BITS-1:0]  vertex_u_o,
  output logic signed [COORD_BITS-1:0]  vertex_v_o,
  output logic [INDEX_BITS-1:0]         vertex_number_o,
  output logic                          last_o
);

  localparam int DW = NumFields * COORD_BITS;

  logic                  push, pop, q_empty, q_full;
  cmd_ctl_t              f_ctl, q_ctl;
  logic [DW-1:0]         f_data, q_data;
  issue_t                issue;
  logic [INDEX_BITS-1:0] number;
  logic [WeightW-1:0]    wu, wv;
  logic [NumCorners-1:0][NumFields-1:0][COORD_BITS-1:0] corners;

  bpt_front #(
    .MAX_RESOLUTION (MAX_RESOLUTION),
    .COORD_BITS     (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .opcode_i   (opcode_i),
    .corner_i   (corner_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .tex_u_i    (tex_u_i),
    .tex_v_i    (tex_v_i),
    .sub_col_i  (sub_col_i),
    .sub_row_i  (sub_row_i),
    .full_i     (q_full),
    .push_o     (push),
    .ctl_o      (f_ctl),
    .data_o     (f_data)
  );

  bpt_cmd_fifo #(
    .DATA_W (DW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ctl_i   (f_ctl),
    .data_i  (f_data),
    .pop_i   (pop),
    .ctl_o   (q_ctl),
    .data_o  (q_data),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  bpt_back #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .ctl_i     (q_ctl),
    .data_i    (q_data),
    .pop_o     (pop),
    .issue_o   (issue),
    .number_o  (number),
    .wu_o      (wu),
    .wv_o      (wv),
    .corners_o (corners)
  );

  bpt_blend #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_blend (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .issue_i         (issue),
    .number_i        (number),
    .wu_i            (wu),
    .wv_i            (wv),
    .corners_i       (corners),
    .vertex_valid_o  (vertex_valid_o),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o),
    .vertex_u_o      (vertex_u_o),
    .vertex_v_o      (vertex_v_o),
    .vertex_number_o (vertex_number_o),
    .last_o          (last_o)
  );

endmodule
